// ===== hw/rtl/gcrb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the great circle range and bearing block.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package gcrb_pkg;

  localparam int ANGLE_W = 32;          // binary angle width, one turn = 2^ANGLE_W
  localparam int STAGES  = 30;          // CORDIC iterations
  localparam int FRAC    = 30;          // fraction bits of sines, cosines and the cosine sum
  localparam int CW      = 36;          // CORDIC datapath width, signed
  localparam int RW      = FRAC + 1;    // bits of the square root
  localparam int VW      = 2 * RW;      // bits of the square root radicand
  localparam int VEC_LAT = STAGES + 2;  // register stages of one vectoring CORDIC
  localparam int RAD_W   = 41;          // radians with 38 fraction bits
  localparam int RAD_SHIFT = 55;        // 32 + 61 - 38
  localparam int RAD_SPLIT = 20;        // split of the radians for the radius multiply
  localparam int DIST_W  = 26;
  localparam int DIST_SHIFT = 38;

  typedef logic signed [CW-1:0] fix_t;
  typedef logic [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    fix_t sum;
    fix_t xv;
    fix_t yv;
    logic clamped;
  } side_t;

  localparam angle_t HALF_TURN = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam fix_t ONE = {{(CW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
  localparam fix_t NEG_ONE = -ONE;
  localparam fix_t GAIN_X = fix_t'(652032874);
  localparam logic [2*CW-1:0] MUL_RND = {{(2*CW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic [31:0] TWO_PI_HI = 32'hC90F_DAA2;
  localparam logic [31:0] TWO_PI_LO = 32'h2168_C235;
  localparam logic [95:0] RAD_RND = 96'd1 << (RAD_SHIFT - 1);
  localparam logic [65:0] DIST_RND = 66'd1 << (DIST_SHIFT - 1);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [23:0] RADIUS_RESET = 24'd6371000;

  // atan(2^-idx) as a binary angle, rounded to nearest.
  function automatic angle_t atan_tab(input int idx);
    angle_t t;
    case (idx)
      0:  t = 32'h2000_0000;
      1:  t = 32'h12E4_051E;
      2:  t = 32'h09FB_385B;
      3:  t = 32'h0511_11D4;
      4:  t = 32'h028B_0D43;
      5:  t = 32'h0145_D7E1;
      6:  t = 32'h00A2_F61E;
      7:  t = 32'h0051_7C55;
      8:  t = 32'h0028_BE53;
      9:  t = 32'h0014_5F2F;
      10: t = 32'h000A_2F98;
      11: t = 32'h0005_17CC;
      12: t = 32'h0002_8BE6;
      13: t = 32'h0001_45F3;
      14: t = 32'h0000_A2FA;
      15: t = 32'h0000_517D;
      16: t = 32'h0000_28BE;
      17: t = 32'h0000_145F;
      18: t = 32'h0000_0A30;
      19: t = 32'h0000_0518;
      20: t = 32'h0000_028C;
      21: t = 32'h0000_0146;
      22: t = 32'h0000_00A3;
      23: t = 32'h0000_0051;
      24: t = 32'h0000_0029;
      25: t = 32'h0000_0014;
      26: t = 32'h0000_000A;
      27: t = 32'h0000_0005;
      28: t = 32'h0000_0003;
      29: t = 32'h0000_0001;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic fix_t atan_fix(input int idx);
    return fix_t'({{(CW-ANGLE_W){1'b0}}, atan_tab(idx)});
  endfunction

  // Fixed point product, magnitude rounded to nearest with ties away from zero.
  function automatic fix_t mulq(input fix_t a, input fix_t b);
    logic neg;
    logic [CW-1:0] ua;
    logic [CW-1:0] ub;
    logic [2*CW-1:0] pr;
    fix_t r;
    neg = a[CW-1] ^ b[CW-1];
    ua = a[CW-1] ? -a : a;
    ub = b[CW-1] ? -b : b;
    pr = ({{CW{1'b0}}, ua} * {{CW{1'b0}}, ub}) + MUL_RND;
    r = fix_t'(pr[FRAC+CW-1:FRAC]);
    return neg ? -r : r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/great_circle_range_bearing_top.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and halts only while
// a result word waits at the output under stall, so in_stall mirrors that output hold.
// The datapath runs through three 32-stage CORDIC and square root pipelines in series.
// Reset (rst, synchronous, active high) clears every valid bit and loads the radius 6371000.
// Top level of the great circle range and bearing block.
// Depends on gcrb_pkg, gcrb_sincos, gcrb_isqrt and gcrb_vector.
`default_nettype none

module great_circle_range_bearing_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  start_lat,
  input  logic signed [31:0]  start_lon,
  input  logic signed [31:0]  end_lat,
  input  logic signed [31:0]  end_lon,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         central_angle,
  output logic [25:0]         distance_m,
  output logic signed [31:0]  azimuth,
  output logic                clamped
);

  localparam int CW = gcrb_pkg::CW;
  localparam int RW = gcrb_pkg::RW;
  localparam int VW = gcrb_pkg::VW;
  localparam int VL = gcrb_pkg::VEC_LAT;
  localparam int RS = gcrb_pkg::RAD_SPLIT;
  localparam int RAD_W = gcrb_pkg::RAD_W;

  // The pipeline moves as one. It halts only when the output register holds a word that
  // the far side is stalling; everything upstream then keeps its contents.
  logic advance;
  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Sphere radius register.
  logic [23:0] radius;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= gcrb_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // Valid bits of the stages held in this module.
  logic v_s0, v_m1, v_m2, v_m3, v_m4, v_f1, v_d1, v_d2, v_d3;

  // Input stage: latitudes and the wrapped longitude difference.
  gcrb_pkg::angle_t lat0_s0, lat1_s0, dlon_s0;

  always_ff @(posedge clk) begin
    if (advance) begin
      lat0_s0 <= gcrb_pkg::angle_t'(start_lat);
      lat1_s0 <= gcrb_pkg::angle_t'(end_lat);
      dlon_s0 <= gcrb_pkg::angle_t'(end_lon - start_lon);
    end
  end

  // Sines and cosines of both latitudes and of the longitude difference.
  logic sc_valid0, sc_valid1, sc_valid2;
  gcrb_pkg::fix_t c0, s0, c1, s1, cd, sd;

  gcrb_sincos u_sc_lat0 (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(v_s0), .ang(lat0_s0),
    .out_valid(sc_valid0), .cos_out(c0), .sin_out(s0)
  );

  gcrb_sincos u_sc_lat1 (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(v_s0), .ang(lat1_s0),
    .out_valid(sc_valid1), .cos_out(c1), .sin_out(s1)
  );

  gcrb_sincos u_sc_dlon (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(v_s0), .ang(dlon_s0),
    .out_valid(sc_valid2), .cos_out(cd), .sin_out(sd)
  );

  // First product stage. The azimuth terms are multiplied through by cos(end_lat),
  // so that a pole gives finite operands.
  gcrb_pkg::fix_t m1_c0c1, m1_s0s1, m1_s0c1, m1_xv, m1_c0s1, m1_cd;

  always_ff @(posedge clk) begin
    if (advance) begin
      m1_c0c1 <= gcrb_pkg::mulq(c0, c1);
      m1_s0s1 <= gcrb_pkg::mulq(s0, s1);
      m1_s0c1 <= gcrb_pkg::mulq(s0, c1);
      m1_xv   <= gcrb_pkg::mulq(sd, c1);
      m1_c0s1 <= gcrb_pkg::mulq(c0, s1);
      m1_cd   <= cd;
    end
  end

  // Second product stage: the terms that also carry cos(dlon).
  gcrb_pkg::fix_t m2_t1, m2_t2, m2_t3, m2_xv, m2_c0s1;

  always_ff @(posedge clk) begin
    if (advance) begin
      m2_t1   <= gcrb_pkg::mulq(m1_c0c1, m1_cd);
      m2_t2   <= m1_s0s1;
      m2_t3   <= gcrb_pkg::mulq(m1_s0c1, m1_cd);
      m2_xv   <= m1_xv;
      m2_c0s1 <= m1_c0s1;
    end
  end

  // Cosine sum, clamped to the closed unit interval, and the azimuth denominator.
  gcrb_pkg::fix_t m3_raw;
  gcrb_pkg::side_t m3_side;
  assign m3_raw = m2_t1 + m2_t2;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (m3_raw > gcrb_pkg::ONE) begin
        m3_side.sum <= gcrb_pkg::ONE;
        m3_side.clamped <= 1'b1;
      end else if (m3_raw < gcrb_pkg::NEG_ONE) begin
        m3_side.sum <= gcrb_pkg::NEG_ONE;
        m3_side.clamped <= 1'b1;
      end else begin
        m3_side.sum <= m3_raw;
        m3_side.clamped <= 1'b0;
      end
      m3_side.xv <= m2_xv;
      m3_side.yv <= m2_c0s1 - m2_t3;
    end
  end

  // Radicand (1 - S)(1 + S); both factors lie in [0, 2] and the product in [0, 1].
  gcrb_pkg::fix_t m4_diff, m4_plus;
  logic [2*RW+1:0] m4_prod;
  logic [VW-1:0] m4_val;
  gcrb_pkg::side_t m4_side;
  assign m4_diff = gcrb_pkg::ONE - m3_side.sum;
  assign m4_plus = gcrb_pkg::ONE + m3_side.sum;
  assign m4_prod = {{(RW+1){1'b0}}, m4_diff[RW:0]} * {{(RW+1){1'b0}}, m4_plus[RW:0]};

  always_ff @(posedge clk) begin
    if (advance) begin
      m4_val <= m4_prod[VW-1:0];
      m4_side <= m3_side;
    end
  end

  // sqrt(1 - S^2), with the other operands riding alongside.
  logic sq_valid;
  logic [RW-1:0] sq_root;
  gcrb_pkg::side_t sq_side;

  gcrb_isqrt u_isqrt (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(v_m4), .val(m4_val),
    .side_in(m4_side), .out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
  );

  // Central angle atan2(sqrt(1 - S^2), S) and azimuth, side by side.
  logic vc_valid, va_valid;
  gcrb_pkg::angle_t vc_ang, va_ang;
  gcrb_pkg::fix_t sq_y;
  assign sq_y = gcrb_pkg::fix_t'({{(CW-RW){1'b0}}, sq_root});

  gcrb_vector u_vec_range (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(sq_valid),
    .xin(sq_side.sum), .yin(sq_y), .out_valid(vc_valid), .ang(vc_ang)
  );

  gcrb_vector u_vec_bearing (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(sq_valid),
    .xin(sq_side.yv), .yin(sq_side.xv), .out_valid(va_valid), .ang(va_ang)
  );

  // Sign of S and the clamp flag follow the vectoring pipelines; bit 1 is the sign.
  logic [1:0] tag_d [0:VL-1];

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_d[0] <= {sq_side.sum[CW-1], sq_side.clamped};
      for (int i = 1; i < VL; i++) begin
        tag_d[i] <= tag_d[i-1];
      end
    end
  end

  // Residue can push the central angle just past a half turn; it is then snapped to
  // zero or to the half turn according to the sign of S.
  gcrb_pkg::angle_t cang_f1, az_f1;
  logic cl_f1;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (vc_ang > gcrb_pkg::HALF_TURN) begin
        cang_f1 <= tag_d[VL-1][1] ? gcrb_pkg::HALF_TURN : '0;
      end else begin
        cang_f1 <= vc_ang;
      end
      az_f1 <= va_ang;
      cl_f1 <= tag_d[VL-1][0];
    end
  end

  // Radians: the angle times 2*pi, split into two 32 by 32 partial products.
  logic [63:0] ph_d1, pl_d1;
  gcrb_pkg::angle_t cang_d1, az_d1;
  logic cl_d1;

  always_ff @(posedge clk) begin
    if (advance) begin
      ph_d1 <= {32'b0, cang_f1} * {32'b0, gcrb_pkg::TWO_PI_HI};
      pl_d1 <= {32'b0, cang_f1} * {32'b0, gcrb_pkg::TWO_PI_LO};
      cang_d1 <= cang_f1;
      az_d1 <= az_f1;
      cl_d1 <= cl_f1;
    end
  end

  logic [95:0] rad_sum;
  logic [RAD_W-1:0] rad_d2;
  gcrb_pkg::angle_t cang_d2, az_d2;
  logic cl_d2;
  assign rad_sum = {ph_d1, 32'b0} + {32'b0, pl_d1} + gcrb_pkg::RAD_RND;

  always_ff @(posedge clk) begin
    if (advance) begin
      rad_d2 <= rad_sum[gcrb_pkg::RAD_SHIFT+RAD_W-1:gcrb_pkg::RAD_SHIFT];
      cang_d2 <= cang_d1;
      az_d2 <= az_d1;
      cl_d2 <= cl_d1;
    end
  end

  // Radius times radians, again in two partial products.
  logic [24+RAD_W-RS-1:0] mh_d3;
  logic [24+RS-1:0] ml_d3;
  gcrb_pkg::angle_t cang_d3, az_d3;
  logic cl_d3;

  always_ff @(posedge clk) begin
    if (advance) begin
      mh_d3 <= {{(RAD_W-RS){1'b0}}, radius} * {24'b0, rad_d2[RAD_W-1:RS]};
      ml_d3 <= {{RS{1'b0}}, radius} * {24'b0, rad_d2[RS-1:0]};
      cang_d3 <= cang_d2;
      az_d3 <= az_d2;
      cl_d3 <= cl_d2;
    end
  end

  // Output register: rounded distance, saturated to its field.
  logic [65:0] dist_sum;
  logic [65-gcrb_pkg::DIST_SHIFT:0] dist_full;
  assign dist_sum = {1'b0, mh_d3, {RS{1'b0}}} + {22'b0, ml_d3} + gcrb_pkg::DIST_RND;
  assign dist_full = dist_sum[65:gcrb_pkg::DIST_SHIFT];

  always_ff @(posedge clk) begin
    if (advance) begin
      central_angle <= cang_d3;
      azimuth <= $signed(az_d3);
      clamped <= cl_d3;
      if (|dist_full[65-gcrb_pkg::DIST_SHIFT:gcrb_pkg::DIST_W]) begin
        distance_m <= gcrb_pkg::DIST_MAX;
      end else begin
        distance_m <= dist_full[gcrb_pkg::DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
      v_m1 <= 1'b0;
      v_m2 <= 1'b0;
      v_m3 <= 1'b0;
      v_m4 <= 1'b0;
      v_f1 <= 1'b0;
      v_d1 <= 1'b0;
      v_d2 <= 1'b0;
      v_d3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v_s0 <= in_valid;
      v_m1 <= sc_valid0;
      v_m2 <= v_m1;
      v_m3 <= v_m2;
      v_m4 <= v_m3;
      v_f1 <= vc_valid;
      v_d1 <= v_f1;
      v_d2 <= v_d1;
      v_d3 <= v_d2;
      out_valid <= v_d3;
    end
  end

  // The three trigonometric pipelines run in lockstep.
  a_sincos_align: assert property (@(posedge clk) disable iff (rst)
    (sc_valid0 == sc_valid1) && (sc_valid0 == sc_valid2))
    else $error("sine and cosine pipelines out of step");

  // Range and bearing vectoring pipelines run in lockstep.
  a_vector_align: assert property (@(posedge clk) disable iff (rst)
    vc_valid == va_valid)
    else $error("vectoring pipelines out of step");

  // The central angle never exceeds a half turn.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (central_angle <= gcrb_pkg::HALF_TURN))
    else $error("central angle beyond a half turn");

  // A zero central angle gives a zero distance whatever the radius.
  a_zero_distance: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (central_angle == '0)) |-> (distance_m == '0))
    else $error("non-zero distance for zero central angle");

endmodule

`default_nettype wire

// ===== hw/rtl/gcrb_sincos.sv =====
// Pipelined rotation CORDIC giving the cosine and sine of a binary angle.
// Depends on gcrb_pkg.
`default_nettype none

module gcrb_sincos (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  gcrb_pkg::angle_t ang,
  output logic             out_valid,
  output gcrb_pkg::fix_t   cos_out,
  output gcrb_pkg::fix_t   sin_out
);

  localparam int N = gcrb_pkg::STAGES;
  localparam int AW = gcrb_pkg::ANGLE_W;
  localparam int CW = gcrb_pkg::CW;

  gcrb_pkg::fix_t x_s [0:N];
  gcrb_pkg::fix_t y_s [0:N];
  gcrb_pkg::fix_t z_s [0:N];
  logic           flip_s [0:N];
  gcrb_pkg::fix_t x_n [1:N];
  gcrb_pkg::fix_t y_n [1:N];
  gcrb_pkg::fix_t z_n [1:N];
  logic [N+1:0]   valid_s;
  logic             flip0;
  gcrb_pkg::angle_t ang0;
  gcrb_pkg::fix_t   z0;

  // Second and third quadrants are folded by a half turn and negated at the end.
  always_comb begin
    flip0 = (ang[AW-1:AW-2] == 2'b01) || (ang[AW-1:AW-2] == 2'b10);
    ang0 = flip0 ? ang - gcrb_pkg::HALF_TURN : ang;
    z0 = gcrb_pkg::fix_t'({{(CW-AW){ang0[AW-1]}}, ang0});
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!z_s[i][CW-1]) begin
        x_n[i+1] = x_s[i] - (y_s[i] >>> i);
        y_n[i+1] = y_s[i] + (x_s[i] >>> i);
        z_n[i+1] = z_s[i] - gcrb_pkg::atan_fix(i);
      end else begin
        x_n[i+1] = x_s[i] + (y_s[i] >>> i);
        y_n[i+1] = y_s[i] - (x_s[i] >>> i);
        z_n[i+1] = z_s[i] + gcrb_pkg::atan_fix(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s <= '0;
    end else if (advance) begin
      valid_s <= {valid_s[N:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_s[0] <= gcrb_pkg::GAIN_X;
      y_s[0] <= '0;
      z_s[0] <= z0;
      flip_s[0] <= flip0;
      for (int i = 1; i <= N; i++) begin
        x_s[i] <= x_n[i];
        y_s[i] <= y_n[i];
        z_s[i] <= z_n[i];
        flip_s[i] <= flip_s[i-1];
      end
      cos_out <= flip_s[N] ? -x_s[N] : x_s[N];
      sin_out <= flip_s[N] ? -y_s[N] : y_s[N];
    end
  end

  assign out_valid = valid_s[N+1];

endmodule

`default_nettype wire

// ===== hw/rtl/gcrb_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, with a sideband word carried alongside.
// Depends on gcrb_pkg.
`default_nettype none

module gcrb_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       in_valid,
  input  logic [gcrb_pkg::VW-1:0]    val,
  input  gcrb_pkg::side_t            side_in,
  output logic                       out_valid,
  output logic [gcrb_pkg::RW-1:0]    root,
  output gcrb_pkg::side_t            side_out
);

  localparam int RW = gcrb_pkg::RW;
  localparam int VW = gcrb_pkg::VW;

  logic [VW-1:0]   rem_s [0:RW];
  logic [RW-1:0]   r_s [0:RW];
  gcrb_pkg::side_t side_s [0:RW];
  logic [VW-1:0]   rem_n [1:RW];
  logic [RW-1:0]   r_n [1:RW];
  logic [VW:0]     trial [0:RW-1];
  logic [RW:0]     valid_s;

  // Stage k settles root bit RW-1-k: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b).
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      trial[k] = ((VW+1)'(r_s[k]) << (RW - k)) + ((VW+1)'(1) << (2 * (RW - 1 - k)));
      if (trial[k] <= {1'b0, rem_s[k]}) begin
        rem_n[k+1] = rem_s[k] - trial[k][VW-1:0];
        r_n[k+1] = r_s[k] | (RW'(1) << (RW - 1 - k));
      end else begin
        rem_n[k+1] = rem_s[k];
        r_n[k+1] = r_s[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s <= '0;
    end else if (advance) begin
      valid_s <= {valid_s[RW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_s[0] <= val;
      r_s[0] <= '0;
      side_s[0] <= side_in;
      for (int k = 1; k <= RW; k++) begin
        rem_s[k] <= rem_n[k];
        r_s[k] <= r_n[k];
        side_s[k] <= side_s[k-1];
      end
    end
  end

  assign out_valid = valid_s[RW];
  assign root = r_s[RW];
  assign side_out = side_s[RW];

endmodule

`default_nettype wire

// ===== hw/rtl/gcrb_vector.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) as a binary angle; atan2(0, 0) reads as zero.
// Depends on gcrb_pkg.
`default_nettype none

module gcrb_vector (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  gcrb_pkg::fix_t   xin,
  input  gcrb_pkg::fix_t   yin,
  output logic             out_valid,
  output gcrb_pkg::angle_t ang
);

  localparam int N = gcrb_pkg::STAGES;
  localparam int CW = gcrb_pkg::CW;

  gcrb_pkg::fix_t   x_s [0:N];
  gcrb_pkg::fix_t   y_s [0:N];
  gcrb_pkg::angle_t z_s [0:N];
  logic             zero_s [0:N];
  gcrb_pkg::fix_t   x_n [1:N];
  gcrb_pkg::fix_t   y_n [1:N];
  gcrb_pkg::angle_t z_n [1:N];
  logic [N+1:0]     valid_s;

  // A vector in the left half plane is turned by a half turn first.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (!y_s[i][CW-1] && (y_s[i] != '0)) begin
        x_n[i+1] = x_s[i] + (y_s[i] >>> i);
        y_n[i+1] = y_s[i] - (x_s[i] >>> i);
        z_n[i+1] = z_s[i] + gcrb_pkg::atan_tab(i);
      end else begin
        x_n[i+1] = x_s[i] - (y_s[i] >>> i);
        y_n[i+1] = y_s[i] + (x_s[i] >>> i);
        z_n[i+1] = z_s[i] - gcrb_pkg::atan_tab(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s <= '0;
    end else if (advance) begin
      valid_s <= {valid_s[N:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x_s[0] <= xin[CW-1] ? -xin : xin;
      y_s[0] <= xin[CW-1] ? -yin : yin;
      z_s[0] <= xin[CW-1] ? gcrb_pkg::HALF_TURN : '0;
      zero_s[0] <= (xin == '0) && (yin == '0);
      for (int i = 1; i <= N; i++) begin
        x_s[i] <= x_n[i];
        y_s[i] <= y_n[i];
        z_s[i] <= z_n[i];
        zero_s[i] <= zero_s[i-1];
      end
      ang <= zero_s[N] ? '0 : z_s[N];
    end
  end

  assign out_valid = valid_s[N+1];

endmodule

`default_nettype wire

// ===== tb/sv/great_circle_range_bearing_top_test.sv =====
// Self-checking testbench for great_circle_range_bearing_top: directed table, then random
// point pairs under several radius settings. Depends on the block's RTL only.
`default_nettype none

module great_circle_range_bearing_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  // One input word: the two points as signed binary angles.
  typedef struct packed {
    logic [31:0] lat0;
    logic [31:0] lon0;
    logic [31:0] lat1;
    logic [31:0] lon1;
  } pair_t;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [31:0] cang;
    logic [25:0] span;
    logic [31:0] az;
    logic        clip;
  } range_t;

  localparam int NSTEP = 30;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 150;   // comfortably past the pipeline latency
  localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;
  localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C235;
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452951;
  localparam longint UNIT = 64'sd1 << 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] start_lat = '0;
  logic signed [31:0] start_lon = '0;
  logic signed [31:0] end_lat = '0;
  logic signed [31:0] end_lon = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] central_angle;
  logic [25:0] distance_m;
  logic signed [31:0] azimuth;
  logic clamped;

  great_circle_range_bearing_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_lat(start_lat), .start_lon(start_lon), .end_lat(end_lat), .end_lon(end_lon),
    .out_valid(out_valid), .out_stall(out_stall),
    .central_angle(central_angle), .distance_m(distance_m),
    .azimuth(azimuth), .clamped(clamped)
  );

  // Predictor state: the arctangent steps and the radius currently loaded in the block.
  longint      arc_step [NSTEP];
  logic [23:0] radius_m = 24'd6371000;

  range_t pending_q [$];
  int     errors = 0;
  int     words_in = 0;
  int     words_out = 0;
  int     clip_seen = 0;
  int     idle_count = 0;
  bit     quiet = 1'b0;      // suspends random idling on both sides
  bit     hold_req = 1'b0;   // asks the receiver for one long hold-off
  bit     finished = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Arctangent of 2^-i as a binary angle, from the odd power series scaled by 1/(2pi).
  function automatic void build_arc_steps();
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [63:0]  q64;
    logic [127:0] prod;
    int p;
    for (int i = 0; i < NSTEP; i++) begin
      if (i == 0) begin
        q64 = 64'd1 << 61;
      end else begin
        acc = '0;
        for (int k = 0; ; k++) begin
          p = 62 - i * (2 * k + 1);
          if (p < 0) break;
          term = (64'd1 << p) / (2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        prod = {64'd0, acc} * {64'd0, INV_TWO_PI};
        q64 = prod[125:62];
      end
      arc_step[i] = longint'((q64 + (64'd1 << 31)) >> 32);
    end
  endfunction

  // Product of two Q30 values, magnitude rounded to nearest.
  function automatic longint q30_mul(longint a, longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] pr;
    longint r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    pr = {64'd0, ua} * {64'd0, ub} + (128'd1 << 29);
    r = longint'(pr[93:30]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Rotating CORDIC: cosine and sine of a binary angle, folded into the right half plane.
  function automatic void rotate(input logic [31:0] ang, output longint cs, output longint sn);
    longint x;
    longint y;
    longint z;
    longint nx;
    bit flip;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang - 32'h8000_0000;
    z = longint'($signed(ang));
    x = longint'((GAIN_Q62 + (64'd1 << 31)) >> 32);
    y = 0;
    for (int i = 0; i < NSTEP; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - arc_step[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + arc_step[i];
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // Vectoring CORDIC: atan2(y, x) as a binary angle; both zero gives zero.
  function automatic logic [31:0] bearing_of(longint y, longint x);
    longint z;
    longint nx;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd1 << 31;
    end
    for (int i = 0; i < NSTEP; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + arc_step[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - arc_step[i];
      end
      x = nx;
    end
    return z[31:0];
  endfunction

  function automatic range_t predict_range(pair_t w);
    range_t r;
    longint c0, s0, c1, s1, cd, sd, cs, root;
    logic [127:0] rad2;
    logic [127:0] sq;
    logic [63:0]  cand;
    logic [127:0] prod;
    logic [63:0]  rad;
    logic [127:0] span_wide;
    rotate(w.lat0, c0, s0);
    rotate(w.lat1, c1, s1);
    rotate(w.lon1 - w.lon0, cd, sd);
    r.clip = 1'b0;
    cs = q30_mul(q30_mul(c0, c1), cd) + q30_mul(s0, s1);
    if (cs > UNIT) begin
      cs = UNIT; r.clip = 1'b1;
    end else if (cs < -UNIT) begin
      cs = -UNIT; r.clip = 1'b1;
    end
    rad2 = {64'd0, 64'(UNIT - cs)} * {64'd0, 64'(UNIT + cs)};
    cand = '0;
    for (int b = 63; b >= 0; b--) begin
      sq = {64'd0, cand | (64'd1 << b)} * {64'd0, cand | (64'd1 << b)};
      if (sq <= rad2) cand = cand | (64'd1 << b);
    end
    root = longint'(cand);
    r.cang = bearing_of(root, cs);
    // CORDIC residue can carry the angle just past the half turn.
    if (r.cang > 32'h8000_0000) r.cang = (cs < 0) ? 32'h8000_0000 : 32'h0;
    r.az = bearing_of(q30_mul(sd, c1), q30_mul(c0, s1) - q30_mul(q30_mul(s0, c1), cd));
    prod = {96'd0, r.cang} * {64'd0, TWO_PI_Q61} + (128'd1 << 54);
    rad = prod[118:55];
    span_wide = ({104'd0, radius_m} * {64'd0, rad} + (128'd1 << 37)) >> 38;
    r.span = (span_wide > 128'h3FF_FFFF) ? 26'h3FF_FFFF : span_wide[25:0];
    return r;
  endfunction

  // Offers one word, holding it until the block takes it, then perhaps leaves a gap.
  task automatic offer_pair(pair_t w);
    start_lat <= w.lat0;
    start_lon <= w.lon0;
    end_lat <= w.lat1;
    end_lon <= w.lon1;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    pending_q.push_back(predict_range(w));
    words_in++;
    if (!quiet && $urandom_range(99, 0) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Lets every outstanding result out, then gives the pipeline time to go fully quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_radius(logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_m = v;
  endtask

  // Random pair. Most points lie inside the latitude range; some sit close to the start
  // point or its antipode so that the cosine sum grazes plus or minus one, and a few
  // use the whole 32-bit latitude range.
  function automatic pair_t random_pair();
    pair_t w;
    int kind;
    kind = $urandom_range(99, 0);
    w.lat0 = 32'($urandom_range(32'h8000_0000, 0)) - 32'h4000_0000;
    w.lon0 = $urandom;
    w.lat1 = 32'($urandom_range(32'h8000_0000, 0)) - 32'h4000_0000;
    w.lon1 = $urandom;
    if (kind < 15) begin
      w.lat1 = w.lat0 + 32'($signed($urandom_range(64, 0)) - 32);
      w.lon1 = w.lon0 + 32'($signed($urandom_range(64, 0)) - 32);
    end else if (kind < 25) begin
      w.lat1 = -w.lat0 + 32'($signed($urandom_range(16, 0)) - 8);
      w.lon1 = w.lon0 + 32'h8000_0000 + 32'($signed($urandom_range(16, 0)) - 8);
    end else if (kind < 35) begin
      w.lat0 = $urandom;
      w.lat1 = $urandom;
    end
    return w;
  endfunction

  // Directed table: zeros, poles, latitudes past a quarter turn, longitude extremes,
  // the same point, an antipodal pair, and a start at a pole.
  pair_t directed [] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'h4000_0000, 32'h0000_0000, 32'h4000_0000, 32'h1234_5678},
    '{32'hC000_0000, 32'h0000_0000, 32'h4000_0000, 32'h0000_0000},
    '{32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 32'h2000_0000},
    '{32'hC000_0000, 32'h7FFF_FFFF, 32'h1000_0000, 32'h8000_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000},
    '{32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
    '{32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000},
    '{32'h1555_5555, 32'h3333_3333, 32'h1555_5555, 32'h3333_3333},
    '{32'h2000_0000, 32'h0000_0000, 32'hE000_0000, 32'h8000_0000},
    '{32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000},
    '{32'h6000_0000, 32'hFFFF_FFFF, 32'hA000_0000, 32'h0000_0001},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h4000_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h4000_0000, 32'h0000_0000},
    '{32'h3FFF_FFFF, 32'hAAAA_AAAA, 32'hC000_0001, 32'h5555_5555},
    '{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001}
  };

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request so that
  // the pipeline halts and pushes back on its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !quiet && ($urandom_range(99, 0) < 28);
    end
  end

  // Result checking and the watchdog on cycles with no word moving either way.
  always @(posedge clk) begin
    range_t want;
    if (!rst && !finished) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("great_circle_range_bearing_top verification failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (clamped) clip_seen++;
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result word, actual %h %h %h %b", $time,
                   central_angle, distance_m, azimuth, clamped);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (central_angle !== want.cang) begin
            $display("%0t: central_angle expected %h actual %h", $time, want.cang,
                     central_angle);
            errors++;
          end
          if (distance_m !== want.span) begin
            $display("%0t: distance_m expected %0d actual %0d", $time, want.span, distance_m);
            errors++;
          end
          if (azimuth !== want.az) begin
            $display("%0t: azimuth expected %h actual %h", $time, want.az, azimuth);
            errors++;
          end
          if (clamped !== want.clip) begin
            $display("%0t: clamped expected %b actual %b", $time, want.clip, clamped);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus: the directed table at the reset radius, then random words under a run of
  // radius settings including both extremes.
  initial begin
    logic [23:0] radii [4];
    build_arc_steps();
    radii = '{24'd0, 24'hFF_FFFF, 24'($urandom), 24'd6371000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) offer_pair(directed[i]);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      load_radius(radii[ph]);
      for (int n = 0; n < 100; n++) begin
        // A run of words with no idling on either side in the second phase.
        quiet = (ph == 1) && (n >= 20) && (n < 80);
        // The long hold-off in the third phase, while words keep coming.
        if (ph == 2 && n == 10) hold_req = 1'b1;
        offer_pair(random_pair());
      end
      quiet = 1'b0;
      drain();
    end
    finished = 1'b1;
    $display("Sent %0d words over five radius settings and checked %0d results,", words_in,
             words_out);
    $display("%0d of them with the cosine sum clamped.", clip_seen);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("great_circle_range_bearing_top verification clean");
    end else begin
      $display("great_circle_range_bearing_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
